### hw/rtl/acfj_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfj_pkg
// Shared types, widths and the rounding helper for the anchor constraint block.
// ----------------------------------------------------------------------------
package acfj_pkg;

	localparam int MAX_VERTICES_DEF = 65536;
	localparam int CNT_W  = 17;   // vertex_count register
	localparam int DW     = 33;   // position minus target
	localparam int PW     = 66;   // product of two differences
	localparam int SW     = 68;   // C and Cdot
	localparam int AW     = 102;  // kc*C + kd*Cdot
	localparam int VW     = 140;  // pre-rounding values
	localparam int QDEPTH = 8;    // job queue between front and back
	localparam int ODEPTH = 8;    // result rows waiting for the receiver

	localparam logic [1:0] REG_STIFF = 2'd0;
	localparam logic [1:0] REG_DAMP  = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef struct packed {
		logic [15:0]           vidx;
		logic signed [DW-1:0]  d0;
		logic signed [DW-1:0]  d1;
		logic signed [DW-1:0]  d2;
		logic signed [PW-1:0]  dd00;
		logic signed [PW-1:0]  dd10;
		logic signed [PW-1:0]  dd11;
		logic signed [PW-1:0]  dd20;
		logic signed [PW-1:0]  dd21;
		logic signed [PW-1:0]  dd22;
		logic signed [AW-1:0]  a;
	} acfj_job_t;

	typedef struct packed {
		logic [17:0] row_index;
		logic [1:0]  axis;
		logic [63:0] force_inc;
		logic [63:0] stiff_col0;
		logic [63:0] stiff_col1;
		logic [63:0] stiff_col2;
		logic [63:0] damp_col0;
		logic [63:0] damp_col1;
		logic [63:0] damp_col2;
		logic        last_row;
	} acfj_row_t;

	// round to nearest, ties up, then saturate to signed 64 bits
	function automatic logic [63:0] round_sat(input logic signed [VW-1:0] x,
		input logic wide_shift);
		logic signed [VW-1:0] r;
		logic signed [VW-1:0] y;
		if (wide_shift) begin
			r = x + (VW'(1) <<< 31);
			y = r >>> 32;
		end else begin
			r = x + (VW'(1) <<< 15);
			y = r >>> 16;
		end
		if ((&y[VW-1:63]) || !(|y[VW-1:63])) begin
			return y[63:0];
		end else if (y[VW-1]) begin
			return 64'h8000_0000_0000_0000;
		end else begin
			return 64'h7FFF_FFFF_FFFF_FFFF;
		end
	endfunction

endpackage

### hw/rtl/acfj_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfj_mul
// Two-stage signed multiplier, operand b cut into 34-bit slices.
// ----------------------------------------------------------------------------
module acfj_mul #(
	parameter int WA = 33,
	parameter int WB = 68
) (
	input  logic                    clk,
	input  logic signed [WA-1:0]    a,
	input  logic signed [WB-1:0]    b,
	output logic signed [WA+WB-1:0] p_s2
);
	localparam int CW   = 34;
	localparam int NCH  = (WB + CW - 1) / CW;
	localparam int WBP  = NCH * CW;
	localparam int PPW  = WA + CW + 1;
	localparam int SUMW = WA + WBP + 1;

	logic signed [WBP-1:0]  bx;
	logic signed [PPW-1:0]  pp_s1 [NCH];
	logic signed [SUMW-1:0] acc;

	assign bx = WBP'(b);

	// partial products, low slices unsigned, top slice signed
	always_ff @(posedge clk) begin
		for (int i = 0; i < NCH; i++) begin
			if (i == NCH - 1) begin
				pp_s1[i] <= a * $signed(bx[i*CW +: CW]);
			end else begin
				pp_s1[i] <= a * $signed({1'b0, bx[i*CW +: CW]});
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NCH; i++) begin
			acc = acc + (SUMW'(pp_s1[i]) <<< (i * CW));
		end
	end

	always_ff @(posedge clk) begin
		p_s2 <= acc[WA+WB-1:0];
	end
endmodule

### hw/rtl/acfj_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfj_fifo
// Small register queue, one write and one read per cycle.
// ----------------------------------------------------------------------------
module acfj_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [WIDTH-1:0]               wdata,
	input  logic                           pop,
	output logic [WIDTH-1:0]               rdata,
	output logic [$clog2(DEPTH+1)-1:0]     count
);
	localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTW-1:0]   wr_ptr_q;
	logic [PTW-1:0]   rd_ptr_q;
	logic [CTW-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign count = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != CTW'(DEPTH))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");
endmodule

### hw/rtl/acfj_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfj_front
// Accepts vertices, forms differences, pair products, C, Cdot and the shared gain term.
// ----------------------------------------------------------------------------
module acfj_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [15:0]           vertex_index,
	input  logic signed [31:0]    pos_x,
	input  logic signed [31:0]    pos_y,
	input  logic signed [31:0]    pos_z,
	input  logic signed [31:0]    target_x,
	input  logic signed [31:0]    target_y,
	input  logic signed [31:0]    target_z,
	input  logic signed [31:0]    vel_x,
	input  logic signed [31:0]    vel_y,
	input  logic signed [31:0]    vel_z,
	input  logic [31:0]           stiffness_gain,
	input  logic [31:0]           damping_gain,
	input  logic [$clog2(acfj_pkg::QDEPTH+1)-1:0] q_count,
	output logic                  push,
	output acfj_pkg::acfj_job_t   job
);
	import acfj_pkg::*;

	localparam int QCW = $clog2(QDEPTH + 1);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [QCW:0] occ;
	logic accept;

	logic [15:0]          vidx_s1, vidx_s2;
	logic signed [DW-1:0] d0_s1, d1_s1, d2_s1;
	logic signed [31:0]   vx_s1, vy_s1, vz_s1;
	logic signed [DW-1:0] d0_s2, d1_s2, d2_s2;
	logic signed [PW-1:0] dd00_s2, dd10_s2, dd11_s2, dd20_s2, dd21_s2, dd22_s2;
	logic signed [64:0]   dv0_s2, dv1_s2, dv2_s2;
	logic signed [SW-1:0] c_s3, cd_s3;
	acfj_job_t            job_s3, job_s4, job_s5;
	logic signed [32:0]   kc, kd;
	logic signed [32+SW:0] kcc_s5, kdcd_s5;

	// credit: everything in flight must fit into the queue
	assign occ      = (QCW+1)'(q_count)
		+ (QCW+1)'($countones({v_s1, v_s2, v_s3, v_s4, v_s5}));
	assign in_ready = occ < (QCW+1)'(QDEPTH);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		vidx_s1 <= vertex_index;
		d0_s1   <= DW'(pos_x) - DW'(target_x);
		d1_s1   <= DW'(pos_y) - DW'(target_y);
		d2_s1   <= DW'(pos_z) - DW'(target_z);
		vx_s1   <= vel_x;
		vy_s1   <= vel_y;
		vz_s1   <= vel_z;

		vidx_s2 <= vidx_s1;
		d0_s2   <= d0_s1;
		d1_s2   <= d1_s1;
		d2_s2   <= d2_s1;
		dd00_s2 <= d0_s1 * d0_s1;
		dd10_s2 <= d1_s1 * d0_s1;
		dd11_s2 <= d1_s1 * d1_s1;
		dd20_s2 <= d2_s1 * d0_s1;
		dd21_s2 <= d2_s1 * d1_s1;
		dd22_s2 <= d2_s1 * d2_s1;
		dv0_s2  <= d0_s1 * vx_s1;
		dv1_s2  <= d1_s1 * vy_s1;
		dv2_s2  <= d2_s1 * vz_s1;

		c_s3  <= SW'(dd00_s2) + SW'(dd11_s2) + SW'(dd22_s2);
		cd_s3 <= (SW'(dv0_s2) + SW'(dv1_s2) + SW'(dv2_s2)) <<< 1;
		job_s3.vidx <= vidx_s2;
		job_s3.d0   <= d0_s2;
		job_s3.d1   <= d1_s2;
		job_s3.d2   <= d2_s2;
		job_s3.dd00 <= dd00_s2;
		job_s3.dd10 <= dd10_s2;
		job_s3.dd11 <= dd11_s2;
		job_s3.dd20 <= dd20_s2;
		job_s3.dd21 <= dd21_s2;
		job_s3.dd22 <= dd22_s2;
		job_s3.a    <= '0;

		job_s4 <= job_s3;
		job_s5 <= job_s4;
	end

	assign kc = $signed({1'b0, stiffness_gain});
	assign kd = $signed({1'b0, damping_gain});

	acfj_mul #(.WA(33), .WB(SW)) u_mul_kc (
		.clk  (clk),
		.a    (kc),
		.b    (c_s3),
		.p_s2 (kcc_s5)
	);

	acfj_mul #(.WA(33), .WB(SW)) u_mul_kd (
		.clk  (clk),
		.a    (kd),
		.b    (cd_s3),
		.p_s2 (kdcd_s5)
	);

	always_comb begin
		job   = job_s5;
		job.a = AW'(kcc_s5) + AW'(kdcd_s5);
	end
	assign push = v_s5;
endmodule

### hw/rtl/acfj_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfj_back
// Walks each queued vertex over its three axes, one row a cycle unless stalled.
// ----------------------------------------------------------------------------
module acfj_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [$clog2(acfj_pkg::QDEPTH+1)-1:0] q_count,
	input  acfj_pkg::acfj_job_t   job,
	output logic                  pop,
	input  logic [31:0]           stiffness_gain,
	input  logic [31:0]           damping_gain,
	input  logic [acfj_pkg::CNT_W-1:0] stride,
	input  logic [$clog2(acfj_pkg::ODEPTH+1)-1:0] of_count,
	output logic                  push_row,
	output acfj_pkg::acfj_row_t   row
);
	import acfj_pkg::*;

	localparam int OCW = $clog2(ODEPTH + 1);

	logic [1:0]  row_q;
	logic        issue;
	logic [OCW:0] occ;

	logic vb_s1, vb_s2, vb_s3, vb_s4, vb_s5;

	logic signed [DW-1:0] dp;
	logic signed [PW-1:0] dq [3];
	logic [17:0]          roff;

	logic [1:0]           p_s1, p_s2, p_s3, p_s4;
	logic [17:0]          ri_s1, ri_s2, ri_s3, ri_s4;
	logic [2:0]           dg_s1, dg_s2, dg_s3;
	logic signed [DW-1:0] dp_s1;
	logic signed [PW-1:0] dq_s1 [3];
	logic signed [AW-1:0] a_s1, a_s2, a_s3;
	logic signed [32:0]   kc, kd;

	logic signed [DW+AW-1:0] da_s3;
	logic signed [32+PW:0]   kcdd_s3 [3];
	logic signed [32+PW:0]   kddd_s3 [3];

	logic signed [VW-1:0] fneg_s4;
	logic signed [VW-1:0] kneg_s4 [3];
	logic signed [VW-1:0] dneg_s4 [3];

	assign occ   = (OCW+1)'(of_count)
		+ (OCW+1)'($countones({vb_s1, vb_s2, vb_s3, vb_s4, vb_s5}));
	assign issue = (q_count != '0) && (occ < (OCW+1)'(ODEPTH));
	assign pop   = issue && (row_q == AXIS_Z);

	// pick this axis' difference and the lower-triangle pair products
	always_comb begin
		unique case (row_q)
			AXIS_X: begin
				dp    = job.d0;
				dq[0] = job.dd00;
				dq[1] = '0;
				dq[2] = '0;
				roff  = '0;
			end
			AXIS_Y: begin
				dp    = job.d1;
				dq[0] = job.dd10;
				dq[1] = job.dd11;
				dq[2] = '0;
				roff  = 18'(stride);
			end
			AXIS_Z: begin
				dp    = job.d2;
				dq[0] = job.dd20;
				dq[1] = job.dd21;
				dq[2] = job.dd22;
				roff  = {stride, 1'b0};
			end
			default: begin
				dp    = '0;
				dq[0] = '0;
				dq[1] = '0;
				dq[2] = '0;
				roff  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= AXIS_X;
			vb_s1 <= 1'b0;
			vb_s2 <= 1'b0;
			vb_s3 <= 1'b0;
			vb_s4 <= 1'b0;
			vb_s5 <= 1'b0;
		end else begin
			if (issue) begin
				row_q <= (row_q == AXIS_Z) ? AXIS_X : row_q + 2'd1;
			end
			vb_s1 <= issue;
			vb_s2 <= vb_s1;
			vb_s3 <= vb_s2;
			vb_s4 <= vb_s3;
			vb_s5 <= vb_s4;
		end
	end

	assign kc = $signed({1'b0, stiffness_gain});
	assign kd = $signed({1'b0, damping_gain});

	always_ff @(posedge clk) begin
		p_s1  <= row_q;
		ri_s1 <= 18'(job.vidx) + roff;
		dg_s1 <= {row_q == AXIS_Z, row_q == AXIS_Y, row_q == AXIS_X};
		dp_s1 <= dp;
		for (int q = 0; q < 3; q++) begin
			dq_s1[q] <= dq[q];
		end
		a_s1  <= job.a;

		p_s2  <= p_s1;
		ri_s2 <= ri_s1;
		dg_s2 <= dg_s1;
		a_s2  <= a_s1;
		p_s3  <= p_s2;
		ri_s3 <= ri_s2;
		dg_s3 <= dg_s2;
		a_s3  <= a_s2;

		// negated exact sums
		p_s4    <= p_s3;
		ri_s4   <= ri_s3;
		fneg_s4 <= -(VW'(da_s3) <<< 1);
		for (int q = 0; q < 3; q++) begin
			kneg_s4[q] <= -((VW'(kcdd_s3[q]) <<< 2)
				+ (dg_s3[q] ? (VW'(a_s3) <<< 1) : VW'(0)));
			dneg_s4[q] <= -(VW'(kddd_s3[q]) <<< 2);
		end

		row.row_index  <= ri_s4;
		row.axis       <= p_s4;
		row.last_row   <= (p_s4 == AXIS_Z);
		row.force_inc  <= round_sat(fneg_s4, 1'b1);
		row.stiff_col0 <= round_sat(kneg_s4[0], 1'b0);
		row.stiff_col1 <= round_sat(kneg_s4[1], 1'b0);
		row.stiff_col2 <= round_sat(kneg_s4[2], 1'b0);
		row.damp_col0  <= round_sat(dneg_s4[0], 1'b0);
		row.damp_col1  <= round_sat(dneg_s4[1], 1'b0);
		row.damp_col2  <= round_sat(dneg_s4[2], 1'b0);
	end

	acfj_mul #(.WA(DW), .WB(AW)) u_mul_da (
		.clk  (clk),
		.a    (dp_s1),
		.b    (a_s1),
		.p_s2 (da_s3)
	);

	for (genvar q = 0; q < 3; q++) begin : g_col
		acfj_mul #(.WA(33), .WB(PW)) u_mul_kc (
			.clk  (clk),
			.a    (kc),
			.b    (dq_s1[q]),
			.p_s2 (kcdd_s3[q])
		);
		acfj_mul #(.WA(33), .WB(PW)) u_mul_kd (
			.clk  (clk),
			.a    (kd),
			.b    (dq_s1[q]),
			.p_s2 (kddd_s3[q])
		);
	end

	assign push_row = vb_s5;

	a_axis_order: assert property (@(posedge clk) disable iff (!arst_n)
		issue && (row_q == AXIS_X) |=> row_q == AXIS_Y)
		else $error("axis sequence broken");
endmodule

### hw/rtl/anchor_constraint_force_jacobian.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anchor_constraint_force_jacobian
// Penalty anchor constraint: force increment and stiffness/damping rows per axis.
// ----------------------------------------------------------------------------
// usage
// - input channel (in_valid/in_ready) takes one item per constrained vertex:
//   index, plus position, anchor target and velocity, each Q16.16
// - output channel (out_valid/out_ready) gives three items per vertex, x, y
//   then z, with last_row set on z; values are Q32.32 and saturate
// - gains and vertex_count sit behind the apb port, written while idle
// - throughput: set by the back end, which builds one row a cycle while the
//   job queue holds a vertex and the output queue has room; the front end
//   takes an item every cycle while the 8-entry job queue has room
// - from input accept to the x row at the outputs: 5 front stages, the job
//   queue, 5 back stages and the output queue
// - a stalled receiver fills the 8-row output queue, then the back end stops
//   issuing, then the job queue fills and in_ready drops; nothing is lost
// - reset empties both queues and all pipelines, gains to zero, count to one
// ----------------------------------------------------------------------------
module anchor_constraint_force_jacobian #(
	parameter int MAX_VERTICES = acfj_pkg::MAX_VERTICES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// apb config port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// vertex items
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        vertex_index,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	// row items
	output logic               out_valid,
	input  logic               out_ready,
	output logic [17:0]        row_index,
	output logic [1:0]         axis,
	output logic signed [63:0] force_inc,
	output logic signed [63:0] stiff_col0,
	output logic signed [63:0] stiff_col1,
	output logic signed [63:0] stiff_col2,
	output logic signed [63:0] damp_col0,
	output logic signed [63:0] damp_col1,
	output logic signed [63:0] damp_col2,
	output logic               last_row
);
	import acfj_pkg::*;

	localparam int QCW = $clog2(QDEPTH + 1);
	localparam int OCW = $clog2(ODEPTH + 1);

	logic [31:0]      kc_q;
	logic [31:0]      kd_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] stride;
	logic             wr_en;

	logic             job_push, job_pop;
	acfj_job_t        job_in, job_head;
	logic [$bits(acfj_job_t)-1:0] job_rdata;
	logic [QCW-1:0]   q_count;

	logic             row_push, row_pop;
	acfj_row_t        row_in, row_head;
	logic [$bits(acfj_row_t)-1:0] row_rdata;
	logic [OCW-1:0]   of_count;

	// config registers, write on the apb access phase
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kc_q    <= '0;
			kd_q    <= '0;
			count_q <= CNT_W'(1);
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_STIFF: kc_q    <= pwdata;
				REG_DAMP:  kd_q    <= pwdata;
				REG_COUNT: count_q <= pwdata[CNT_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_STIFF: prdata = kc_q;
			REG_DAMP:  prdata = kd_q;
			REG_COUNT: prdata = 32'(count_q);
			default:   prdata = '0;
		endcase
	end

	// row stride, clamped to the largest mesh the block is built for
	assign stride = ({{(32-CNT_W){1'b0}}, count_q} > 32'(MAX_VERTICES))
		? CNT_W'(MAX_VERTICES) : count_q;

	acfj_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.vertex_index   (vertex_index),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z),
		.target_x       (target_x),
		.target_y       (target_y),
		.target_z       (target_z),
		.vel_x          (vel_x),
		.vel_y          (vel_y),
		.vel_z          (vel_z),
		.stiffness_gain (kc_q),
		.damping_gain   (kd_q),
		.q_count        (q_count),
		.push           (job_push),
		.job            (job_in)
	);

	// job queue between front and back
	acfj_fifo #(.WIDTH($bits(acfj_job_t)), .DEPTH(QDEPTH)) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_in),
		.pop    (job_pop),
		.rdata  (job_rdata),
		.count  (q_count)
	);
	assign job_head = acfj_job_t'(job_rdata);

	acfj_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_count        (q_count),
		.job            (job_head),
		.pop            (job_pop),
		.stiffness_gain (kc_q),
		.damping_gain   (kd_q),
		.stride         (stride),
		.of_count       (of_count),
		.push_row       (row_push),
		.row            (row_in)
	);

	// result rows waiting for the receiver
	acfj_fifo #(.WIDTH($bits(acfj_row_t)), .DEPTH(ODEPTH)) u_row_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (row_push),
		.wdata  (row_in),
		.pop    (row_pop),
		.rdata  (row_rdata),
		.count  (of_count)
	);
	assign row_head = acfj_row_t'(row_rdata);

	assign out_valid  = (of_count != '0);
	assign row_pop    = out_valid && out_ready;
	assign row_index  = row_head.row_index;
	assign axis       = row_head.axis;
	assign force_inc  = row_head.force_inc;
	assign stiff_col0 = row_head.stiff_col0;
	assign stiff_col1 = row_head.stiff_col1;
	assign stiff_col2 = row_head.stiff_col2;
	assign damp_col0  = row_head.damp_col0;
	assign damp_col1  = row_head.damp_col1;
	assign damp_col2  = row_head.damp_col2;
	assign last_row   = row_head.last_row;

	a_last_is_z: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_row |-> axis == AXIS_Z)
		else $error("last_row on a row other than z");
endmodule
